// ===== sv/led_blink_pattern_sequencer_assert.svh =====
// assertion macros for the led blink pattern sequencer checker
// no dependencies; included by the checker file
`ifndef LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH
`define LED_BLINK_PATTERN_SEQUENCER_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define LBPS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define LBPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds through reset
`define LBPS_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lbps_pkg.sv =====
// shared types and constants for the led blink pattern sequencer
// no dependencies
package lbps_pkg;

    localparam int DEF_TIME_BITS = 16;
    localparam int PULSE_W       = 8;
    localparam int DUR_W         = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SOLID = 2'd1,
        CMD_BLINK = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_COUNT   = 3'd0,
        CFG_ON_TIME       = 3'd1,
        CFG_OFF_TIME      = 3'd2,
        CFG_REST_TIME     = 3'd3,
        CFG_REPEAT_ENABLE = 3'd4,
        CFG_INVERT_OUTPUT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_cmd cmd;
        logic solid_level;
    } t_in;

    typedef struct packed {
        logic led_level;
        logic blink_active;
    } t_out;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_count;
        logic [DUR_W-1:0]   on_time;
        logic [DUR_W-1:0]   off_time;
        logic [DUR_W-1:0]   rest_time;
        logic               repeat_enable;
        logic               invert_output;
    } t_cfg;

endpackage

// ===== sv/lbps_cfg.sv =====
// configuration register file of the led blink pattern sequencer
// depends on lbps_pkg
module lbps_cfg
    import lbps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_PULSE_COUNT:   r_cfg.pulse_count   <= i_wr_data[PULSE_W-1:0];
                CFG_ON_TIME:       r_cfg.on_time       <= i_wr_data[DUR_W-1:0];
                CFG_OFF_TIME:      r_cfg.off_time      <= i_wr_data[DUR_W-1:0];
                CFG_REST_TIME:     r_cfg.rest_time     <= i_wr_data[DUR_W-1:0];
                CFG_REPEAT_ENABLE: r_cfg.repeat_enable <= i_wr_data[0];
                CFG_INVERT_OUTPUT: r_cfg.invert_output <= i_wr_data[0];
                default: begin
                    // writes past the last register are dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/lbps_core.sv =====
// sequencer state and next-state logic for one item
// depends on lbps_pkg
module lbps_core
    import lbps_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_result
);

    localparam int EXT_W = TIME_BITS + DUR_W;

    logic                 r_blink_mode;
    logic                 r_phase_on;
    logic [PULSE_W-1:0]   r_pulses_done;
    logic [TIME_BITS-1:0] r_ticks_left;
    logic                 r_pin_level;

    logic                 n_blink_mode;
    logic                 n_phase_on;
    logic [PULSE_W-1:0]   n_pulses_done;
    logic [TIME_BITS-1:0] n_ticks_left;
    logic                 n_pin_level;

    logic [EXT_W-1:0]     on_ext;
    logic [EXT_W-1:0]     off_ext;
    logic [EXT_W-1:0]     rest_ext;
    logic [TIME_BITS-1:0] ticks_dec;

    // durations are masked or zero extended to the timer width
    assign on_ext   = EXT_W'(i_cfg.on_time);
    assign off_ext  = EXT_W'(i_cfg.off_time);
    assign rest_ext = EXT_W'(i_cfg.rest_time);
    assign ticks_dec = (r_ticks_left != '0) ? r_ticks_left - TIME_BITS'(1) : r_ticks_left;

    always_comb begin
        n_blink_mode  = r_blink_mode;
        n_phase_on    = r_phase_on;
        n_pulses_done = r_pulses_done;
        n_ticks_left  = r_ticks_left;
        n_pin_level   = r_pin_level;
        unique case (i_item.cmd)
            CMD_TICK: begin
                if (r_blink_mode) begin
                    n_ticks_left = ticks_dec;
                    if (ticks_dec == '0) begin
                        priority if (r_phase_on) begin
                            n_pin_level   = i_cfg.invert_output;
                            n_ticks_left  = off_ext[TIME_BITS-1:0];
                            n_pulses_done = r_pulses_done + PULSE_W'(1);
                            n_phase_on    = 1'b0;
                        end else if (r_pulses_done >= i_cfg.pulse_count) begin
                            // end of pattern: rest or fall back to solid
                            if (!i_cfg.repeat_enable) begin
                                n_blink_mode = 1'b0;
                            end else begin
                                n_pulses_done = '0;
                                n_ticks_left  = rest_ext[TIME_BITS-1:0];
                            end
                        end else begin
                            n_pin_level  = ~i_cfg.invert_output;
                            n_ticks_left = on_ext[TIME_BITS-1:0];
                            n_phase_on   = 1'b1;
                        end
                    end
                end
            end
            CMD_SOLID: begin
                n_pin_level  = i_item.solid_level;
                n_blink_mode = 1'b0;
            end
            CMD_BLINK: begin
                n_blink_mode  = 1'b1;
                n_pulses_done = '0;
                n_phase_on    = 1'b0;
                n_ticks_left  = '0;
            end
            default: begin
                // unused code leaves the state alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_mode  <= 1'b0;
            r_phase_on    <= 1'b0;
            r_pulses_done <= '0;
            r_ticks_left  <= '0;
            r_pin_level   <= 1'b0;
        end else if (i_adv) begin
            r_blink_mode  <= n_blink_mode;
            r_phase_on    <= n_phase_on;
            r_pulses_done <= n_pulses_done;
            r_ticks_left  <= n_ticks_left;
            r_pin_level   <= n_pin_level;
        end
    end

    assign o_result.led_level    = n_pin_level;
    assign o_result.blink_active = n_blink_mode;

endmodule

// ===== sv/led_blink_pattern_sequencer.sv =====
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle unless a held result stalls the input register
// the timer is a TIME_BITS down counter stepped once per tick item
// reset: synchronous active low; clears config, sequencer state and both stages
// after reset the led is off in solid mode
module led_blink_pattern_sequencer
    import lbps_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_out core_result;

    logic r_in_valid;
    t_in  r_in_data;
    logic r_out_valid;
    t_out r_out_data;
    logic adv;

    // item moves from input register into result register
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    lbps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    lbps_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in_data),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/lbps_checker.sv =====
// port-level checks for the led blink pattern sequencer, bound to the top level
// depends on lbps_pkg and led_blink_pattern_sequencer_assert.svh
`include "led_blink_pattern_sequencer_assert.svh"

module lbps_checker
    import lbps_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    // reset empties both stages and opens the input
    `LBPS_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && o_in_ready, "result valid or input closed after reset")

    // an empty result stage never blocks the input
    `LBPS_ASSERT_SAME(a_empty_takes, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input stalled with empty result stage")

    // a consumer that is ready never stalls the producer
    `LBPS_ASSERT_SAME(a_flow_through, i_clk, i_rst_n, i_out_ready, o_in_ready, "input stalled while output ready")

    // stalled result holds
    `LBPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")

endmodule

bind led_blink_pattern_sequencer lbps_checker u_lbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
